// File: sv/rfb_pkg.sv
// ============================================================================
// rfb_pkg
// Shared types, constants and the breathing sine table of the RGB fade driver.
// ============================================================================
package rfb_pkg;

    // Width of the breathing phase accumulator and of the sine table address.
    localparam int PHASE_BITS     = 10;
    localparam int SINE_ADDR_BITS = 8;
    localparam int SINE_DEPTH     = 1 << SINE_ADDR_BITS;

    localparam int COLOR_W   = 8;
    localparam int CURRENT_W = 16;
    localparam int FADE_W    = 9;
    localparam int PSTEP_W   = 10;
    localparam int FACTOR_W  = 9;
    localparam int PROD_W    = CURRENT_W + FADE_W;

    localparam int NUM_CH = 3;
    localparam int CH_W   = 2;

    localparam logic [FADE_W-1:0] FADE_FULL       = FADE_W'(256);
    localparam logic [FADE_W-1:0] FADE_STEP_RESET = FADE_W'(8);
    localparam logic [PSTEP_W-1:0] PHASE_STEP_RESET = PSTEP_W'(8);

    // Configuration port.
    localparam int CFG_INDEX_W = 1;
    localparam int CFG_DATA_W  = 10;
    localparam logic [CFG_INDEX_W-1:0] CFG_FADE_STEP  = 1'b0;
    localparam logic [CFG_INDEX_W-1:0] CFG_PHASE_STEP = 1'b1;

    typedef enum logic [1:0] {
        CMD_TICK = 2'd0,
        CMD_SET  = 2'd1,
        CMD_OFF  = 2'd2
    } cmd_code_t;

    typedef struct packed {
        logic [1:0]         cmd;
        logic [COLOR_W-1:0] target_red;
        logic [COLOR_W-1:0] target_green;
        logic [COLOR_W-1:0] target_blue;
        logic               pulse_enable;
    } item_t;

    typedef struct packed {
        logic [COLOR_W-1:0] drive_red;
        logic [COLOR_W-1:0] drive_green;
        logic [COLOR_W-1:0] drive_blue;
    } result_t;

    // Commands from the controller to the datapath, valid for one cycle.
    typedef struct packed {
        logic            set_goal;
        logic            clear;
        logic            phase_adv;
        logic            fade_mul;
        logic            fade_upd;
        logic            drv_mul;
        logic            drv_store;
        logic            load_result;
        logic            zero_result;
        logic [CH_W-1:0] ch;
    } dp_cmd_t;

    typedef logic [FACTOR_W-1:0] sine_rom_t [SINE_DEPTH];

    // Shift-and-subtract quotient, used only while building the table.
    function automatic longint const_div(input longint numer, input longint denom);
        longint quo;
        longint rem;
        quo = 0;
        rem = 0;
        for (int b = 40; b >= 0; b--)
        begin
            rem = (rem << 1) | ((numer >> b) & 1);
            quo = quo << 1;
            if (rem >= denom)
            begin
                rem = rem - denom;
                quo = quo | 1;
            end
        end
        return quo;
    endfunction

    // Breathing factor table: round(256 * (0.6 + 0.4 * s)) with s the
    // rational sine approximation over each half of the table.
    function automatic sine_rom_t build_sine_rom();
        sine_rom_t rom;
        longint    h;
        longint    k;
        longint    u;
        longint    p;
        longint    den;
        longint    num;
        longint    q;
        h = longint'(SINE_DEPTH) >> 1;
        for (int i = 0; i < SINE_DEPTH; i++) begin
            k   = longint'(i);
            u   = (k >= h) ? k - h : k;
            p   = u * (h - u);
            den = 5 * h * h - 4 * p;
            num = (k >= h) ? (3 * den - 32 * p) : (3 * den + 32 * p);
            q   = 5 * den;
            rom[i] = FACTOR_W'(const_div(256 * num + (q >> 1), q));
        end
        return rom;
    endfunction

    localparam sine_rom_t SINE_ROM = build_sine_rom();

    // Top address bits of the phase, zero-filled below when the phase is
    // narrower than the table address.
    function automatic logic [SINE_ADDR_BITS-1:0] rom_addr(
        input logic [PHASE_BITS-1:0] phase
    );
        logic [PHASE_BITS+SINE_ADDR_BITS-1:0] wide;
        wide = {phase, {SINE_ADDR_BITS{1'b0}}};
        return wide[PHASE_BITS+SINE_ADDR_BITS-1 -: SINE_ADDR_BITS];
    endfunction

endpackage

// File: sv/rfb_datapath.sv
// ============================================================================
// rfb_datapath
// Colour state, configuration, phase accumulator and shared multiplier.
// ============================================================================
module rfb_datapath (
    input  logic                                clk,
    input  logic                                rst_n,
    input  rfb_pkg::dp_cmd_t                    cmd,
    input  rfb_pkg::item_t                      item,
    input  logic                                cfg_we,
    input  logic [rfb_pkg::CFG_INDEX_W-1:0]     cfg_index,
    input  logic [rfb_pkg::CFG_DATA_W-1:0]      cfg_data,
    output rfb_pkg::result_t                    result
);

    logic [rfb_pkg::FADE_W-1:0]     fade_step_reg;
    logic [rfb_pkg::PSTEP_W-1:0]    phase_step_reg;
    logic [rfb_pkg::PHASE_BITS-1:0] phase_reg;
    logic                           breathe_reg;
    logic [rfb_pkg::COLOR_W-1:0]    goal_reg [rfb_pkg::NUM_CH];
    logic [rfb_pkg::CURRENT_W-1:0]  cur_reg  [rfb_pkg::NUM_CH];

    logic [rfb_pkg::FACTOR_W-1:0]   factor_reg;
    logic [rfb_pkg::PROD_W-1:0]     prod_reg;
    logic                           dir_reg;
    logic [rfb_pkg::COLOR_W-1:0]    drv_reg [rfb_pkg::NUM_CH];
    rfb_pkg::result_t               result_reg;

    logic [rfb_pkg::CURRENT_W-1:0]  cur_sel;
    logic [rfb_pkg::CURRENT_W-1:0]  tgt;
    logic                           up;
    logic [rfb_pkg::CURRENT_W-1:0]  span;
    logic [rfb_pkg::FADE_W-1:0]     fade_f;
    logic [rfb_pkg::CURRENT_W-1:0]  mul_a;
    logic [rfb_pkg::FADE_W-1:0]     mul_b;
    logic [rfb_pkg::PROD_W-1:0]     mul_p;
    logic [rfb_pkg::PROD_W-1:0]     rounded;
    logic [rfb_pkg::CURRENT_W-1:0]  move;
    logic [rfb_pkg::CURRENT_W-1:0]  cur_next;
    logic [rfb_pkg::FACTOR_W-1:0]   scaled;
    logic [rfb_pkg::COLOR_W-1:0]    drv_next;
    logic [rfb_pkg::PHASE_BITS-1:0] phase_next;

    always_comb
    begin
        cur_sel = cur_reg[cmd.ch];
        tgt     = {goal_reg[cmd.ch], {rfb_pkg::CURRENT_W - rfb_pkg::COLOR_W{1'b0}}};
        up      = tgt >= cur_sel;
        span    = up ? (tgt - cur_sel) : (cur_sel - tgt);
        fade_f  = (fade_step_reg > rfb_pkg::FADE_FULL) ? rfb_pkg::FADE_FULL : fade_step_reg;

        // One multiplier serves both the fade distance and the breathing scale.
        mul_a = cmd.fade_mul ? span : cur_sel;
        mul_b = cmd.fade_mul ? fade_f : factor_reg;
        mul_p = rfb_pkg::PROD_W'(mul_a) * rfb_pkg::PROD_W'(mul_b);

        // Round the move up so that, with a nonzero fade step, the channel always lands on its goal.
        rounded  = prod_reg + rfb_pkg::PROD_W'(255);
        move     = rounded[rfb_pkg::CURRENT_W+7:8];
        cur_next = dir_reg ? (cur_sel + move) : (cur_sel - move);

        scaled = prod_reg[rfb_pkg::PROD_W-1:rfb_pkg::CURRENT_W];
        if (!breathe_reg)
            drv_next = cur_sel[rfb_pkg::CURRENT_W-1:rfb_pkg::CURRENT_W-rfb_pkg::COLOR_W];
        else if (scaled[rfb_pkg::FACTOR_W-1])
            drv_next = '1;
        else
            drv_next = scaled[rfb_pkg::COLOR_W-1:0];

        phase_next = phase_reg + rfb_pkg::PHASE_BITS'(phase_step_reg);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fade_step_reg  <= rfb_pkg::FADE_STEP_RESET;
            phase_step_reg <= rfb_pkg::PHASE_STEP_RESET;
            phase_reg      <= '0;
            breathe_reg    <= 1'b0;
            for (int i = 0; i < rfb_pkg::NUM_CH; i++)
            begin
                goal_reg[i] <= '0;
                cur_reg[i]  <= '0;
            end
        end
        else
        begin
            if (cfg_we)
            begin
                case (cfg_index)
                    rfb_pkg::CFG_FADE_STEP:  fade_step_reg  <= cfg_data[rfb_pkg::FADE_W-1:0];
                    rfb_pkg::CFG_PHASE_STEP: phase_step_reg <= cfg_data[rfb_pkg::PSTEP_W-1:0];
                    default: ;
                endcase
            end
            if (cmd.phase_adv)
                phase_reg <= phase_next;
            if (cmd.set_goal)
            begin
                goal_reg[0] <= item.target_red;
                goal_reg[1] <= item.target_green;
                goal_reg[2] <= item.target_blue;
                breathe_reg <= item.pulse_enable;
            end
            if (cmd.clear)
            begin
                breathe_reg <= 1'b0;
                for (int i = 0; i < rfb_pkg::NUM_CH; i++)
                begin
                    goal_reg[i] <= '0;
                    cur_reg[i]  <= '0;
                end
            end
            if (cmd.fade_upd)
                cur_reg[cmd.ch] <= cur_next;
        end
    end

    always_ff @(posedge clk)
    begin
        factor_reg <= rfb_pkg::SINE_ROM[rfb_pkg::rom_addr(phase_reg)];
        if (cmd.fade_mul || cmd.drv_mul)
            prod_reg <= mul_p;
        if (cmd.fade_mul)
            dir_reg <= up;
        if (cmd.drv_store)
            drv_reg[cmd.ch] <= drv_next;
        if (cmd.load_result)
        begin
            result_reg.drive_red   <= drv_reg[0];
            result_reg.drive_green <= drv_reg[1];
            result_reg.drive_blue  <= drv_reg[2];
        end
        else if (cmd.zero_result)
            result_reg <= '0;
    end

    assign result = result_reg;

endmodule

// File: sv/rfb_ctrl.sv
// ============================================================================
// rfb_ctrl
// Sequencer: decodes items, steps the three channels, owns the result handshake.
// ============================================================================
module rfb_ctrl (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              item_valid,
    output logic              item_stall,
    input  logic [1:0]        item_cmd,
    output logic              result_valid,
    input  logic              result_stall,
    output rfb_pkg::dp_cmd_t  cmd
);

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_FADE_MUL,
        ST_FADE_UPD,
        ST_DRV_MUL,
        ST_DRV_STORE,
        ST_EMIT,
        ST_EMIT_ZERO
    } state_t;

    localparam logic [rfb_pkg::CH_W-1:0] LAST_CH = rfb_pkg::CH_W'(rfb_pkg::NUM_CH - 1);

    state_t                    state_reg;
    logic [rfb_pkg::CH_W-1:0]  ch_reg;
    logic                      result_valid_reg;
    logic                      accept;
    logic                      slot_free;
    logic                      emit_now;

    assign item_stall   = (state_reg != ST_IDLE);
    assign accept       = item_valid && (state_reg == ST_IDLE);
    assign slot_free    = !result_valid_reg || !result_stall;
    assign emit_now     = ((state_reg == ST_EMIT) || (state_reg == ST_EMIT_ZERO)) && slot_free;
    assign result_valid = result_valid_reg;

    always_comb
    begin
        cmd    = '0;
        cmd.ch = ch_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    cmd.set_goal  = (item_cmd == rfb_pkg::CMD_SET);
                    cmd.phase_adv = (item_cmd == rfb_pkg::CMD_TICK);
                    cmd.clear     = (item_cmd == rfb_pkg::CMD_OFF);
                end
            end
            ST_FADE_MUL:  cmd.fade_mul    = 1'b1;
            ST_FADE_UPD:  cmd.fade_upd    = 1'b1;
            ST_DRV_MUL:   cmd.drv_mul     = 1'b1;
            ST_DRV_STORE: cmd.drv_store   = 1'b1;
            ST_EMIT:      cmd.load_result = slot_free;
            ST_EMIT_ZERO: cmd.zero_result = slot_free;
            default: ;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= ST_IDLE;
            ch_reg           <= '0;
            result_valid_reg <= 1'b0;
        end
        else
        begin
            if (emit_now)
                result_valid_reg <= 1'b1;
            else if (result_valid_reg && !result_stall)
                result_valid_reg <= 1'b0;
            case (state_reg)
                ST_IDLE:
                begin
                    ch_reg <= '0;
                    if (accept)
                    begin
                        if (item_cmd == rfb_pkg::CMD_TICK)
                            state_reg <= ST_FADE_MUL;
                        else if (item_cmd == rfb_pkg::CMD_OFF)
                            state_reg <= ST_EMIT_ZERO;
                    end
                end
                ST_FADE_MUL:  state_reg <= ST_FADE_UPD;
                ST_FADE_UPD:  state_reg <= ST_DRV_MUL;
                ST_DRV_MUL:   state_reg <= ST_DRV_STORE;
                ST_DRV_STORE:
                begin
                    if (ch_reg == LAST_CH)
                        state_reg <= ST_EMIT;
                    else
                    begin
                        ch_reg    <= ch_reg + rfb_pkg::CH_W'(1);
                        state_reg <= ST_FADE_MUL;
                    end
                end
                ST_EMIT, ST_EMIT_ZERO:
                begin
                    if (slot_free)
                        state_reg <= ST_IDLE;
                end
                default: state_reg <= ST_IDLE;
            endcase
        end
    end

endmodule

// File: sv/rgb_fade_breathe_driver_core.sv
// ============================================================================
// rgb_fade_breathe_driver_core
// RGB pixel driver with exponential colour fade and sine breathing.
// ============================================================================
// Usage: items arrive on the item channel (item_valid / item_stall / item).
// A set item loads the goal colour and the breathing flag and gives no
// result. An off item clears goal, current colour and the flag and gives
// one all-zero result. A tick item advances the breathing phase, moves each
// channel toward its goal and gives one result. After an off or tick item
// the block takes no new item until its result is in the output register.
// The tick sequence is set by the single shared multiplier, which is used
// twice for each of the three colour channels (fade distance, then
// breathing scale), each use followed by a register stage. Code 3 is ignored.
// Results leave on result_valid / result_stall / result through an output
// register: while the receiver stalls, the result holds, and the block may
// still accept and work on the next item, waiting at its end for the slot.
// Reset clears colour state, sets fade_step and phase_step to 8, and drops
// result_valid. Configuration writes (cfg_we, cfg_index, cfg_data) take effect
// at once and are meant for idle periods.
// ============================================================================
module rgb_fade_breathe_driver_core (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                item_valid,
    output logic                                item_stall,
    input  rfb_pkg::item_t                      item,
    output logic                                result_valid,
    input  logic                                result_stall,
    output rfb_pkg::result_t                    result,
    input  logic                                cfg_we,
    input  logic [rfb_pkg::CFG_INDEX_W-1:0]     cfg_index,
    input  logic [rfb_pkg::CFG_DATA_W-1:0]      cfg_data
);

    // Per-cycle commands from the sequencer to the datapath.
    rfb_pkg::dp_cmd_t dp_cmd;

    // The sequencer decodes the command field and walks the channels.
    rfb_ctrl u_ctrl (
        .clk          (clk),
        .rst_n        (rst_n),
        .item_valid   (item_valid),
        .item_stall   (item_stall),
        .item_cmd     (item.cmd),
        .result_valid (result_valid),
        .result_stall (result_stall),
        .cmd          (dp_cmd)
    );

    // The datapath holds all colour state and the result register.
    rfb_datapath u_datapath (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd       (dp_cmd),
        .item      (item),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .result    (result)
    );

endmodule

// File: verif/rgb_fade_breathe_driver_core_tb.sv
// ============================================================================
// rgb_fade_breathe_driver_core_tb
// Self-checking testbench for the RGB fade and breathing pixel driver.
// ============================================================================
// A scoreboard object keeps its own copy of the colour state, the goal, the
// breathing flag, the phase and both rate registers. For every item that the
// block accepts it predicts the pixel levels, and every result the block
// hands out is compared with the oldest prediction. A directed opening covers
// the extremes and every command. Random phases with varied rate settings
// follow, with idle gaps and stalls on both sides of the block.
// ============================================================================
module rgb_fade_breathe_driver_core_tb;

    import rfb_pkg::*;

    // Code 3 is not a command; the block must ignore it.
    localparam logic [1:0] CMD_UNUSED = 2'd3;

    // Settling time after the last result.
    localparam int SETTLE_CYCLES = 24;
    localparam int CYCLE_LIMIT   = 600000;
    localparam int RANDOM_ITEMS  = 830;
    localparam int HOLD_CYCLES   = 300;
    localparam int SHOW_LIMIT    = 10;

    // ------------------------------------------------------------------------
    // Scoreboard: predicts the pixel levels and checks the block's results.
    // ------------------------------------------------------------------------
    class pixel_scoreboard;
        logic [CURRENT_W-1:0] level [NUM_CH];
        logic [COLOR_W-1:0]   goal  [NUM_CH];
        logic                 breathing;
        logic [PHASE_BITS-1:0] phase;
        logic [FADE_W-1:0]    fade_rate;
        logic [PSTEP_W-1:0]   phase_rate;
        logic [FACTOR_W-1:0]  breath_lut [SINE_DEPTH];
        result_t              pending [$];
        int                   fails;
        int                   shown;
        int                   checked;
        int                   ticks;
        int                   sets;
        int                   offs;
        int                   ignored;

        function new();
            longint half;
            longint u;
            longint p;
            longint den;
            longint num;
            half = longint'(SINE_DEPTH) / 2;
            // Breathing factor 256 * (0.6 + 0.4 * s), s from the rational sine
            // approximation 16p / (5H^2 - 4p), rounded to nearest. The second
            // half of the table is the negative half wave.
            for (int k = 0; k < SINE_DEPTH; k++)
            begin
                u   = (k >= half) ? k - half : longint'(k);
                p   = u * (half - u);
                den = 5 * half * half - 4 * p;
                num = (k >= half) ? 3 * den - 32 * p : 3 * den + 32 * p;
                breath_lut[k] = FACTOR_W'((2 * 256 * num + 5 * den) / (10 * den));
            end
            for (int c = 0; c < NUM_CH; c++)
            begin
                level[c] = '0;
                goal[c]  = '0;
            end
            breathing  = 1'b0;
            phase      = '0;
            fade_rate  = FADE_STEP_RESET;
            phase_rate = PHASE_STEP_RESET;
            fails      = 0;
            shown      = 0;
            checked    = 0;
            ticks      = 0;
            sets       = 0;
            offs       = 0;
            ignored    = 0;
        endfunction

        // Move a Q8.8 level toward its goal by ceil(distance * f / 256).
        function logic [CURRENT_W-1:0] faded_level(logic [CURRENT_W-1:0] cur,
                                                   logic [COLOR_W-1:0] aim,
                                                   logic [FADE_W-1:0] f);
            int unsigned dest;
            int unsigned span;
            int unsigned move;
            dest = {aim, 8'h00};
            if (dest >= cur)
            begin
                span = dest - cur;
                move = (span * f + 255) >> 8;
                return CURRENT_W'(cur + move);
            end
            span = cur - dest;
            move = (span * f + 255) >> 8;
            return CURRENT_W'(cur - move);
        endfunction

        function logic [COLOR_W-1:0] pixel_level(logic [CURRENT_W-1:0] cur,
                                                 int unsigned factor);
            int unsigned scaled;
            if (!breathing)
                return cur[CURRENT_W-1 -: COLOR_W];
            scaled = (cur * factor) >> 16;
            return (scaled > 255) ? COLOR_W'(255) : COLOR_W'(scaled);
        endfunction

        // Called for every accepted item; queues the result it causes.
        function void note_item(item_t it);
            result_t     r;
            logic [FADE_W-1:0] f;
            int unsigned factor;
            case (it.cmd)
                CMD_SET:
                begin
                    goal[0]   = it.target_red;
                    goal[1]   = it.target_green;
                    goal[2]   = it.target_blue;
                    breathing = it.pulse_enable;
                    sets++;
                end
                CMD_OFF:
                begin
                    // The phase and both rates are kept; levels, goals and breathing are cleared.
                    for (int c = 0; c < NUM_CH; c++)
                    begin
                        level[c] = '0;
                        goal[c]  = '0;
                    end
                    breathing = 1'b0;
                    pending.push_back('0);
                    offs++;
                end
                CMD_TICK:
                begin
                    phase = PHASE_BITS'(phase + phase_rate);
                    f = (fade_rate > FADE_FULL) ? FADE_FULL : fade_rate;
                    for (int c = 0; c < NUM_CH; c++)
                        level[c] = faded_level(level[c], goal[c], f);
                    factor = breath_lut[phase >> (PHASE_BITS - SINE_ADDR_BITS)];
                    r.drive_red   = pixel_level(level[0], factor);
                    r.drive_green = pixel_level(level[1], factor);
                    r.drive_blue  = pixel_level(level[2], factor);
                    pending.push_back(r);
                    ticks++;
                end
                default:
                    ignored++;
            endcase
        endfunction

        // Called for every accepted result.
        function void check_result(result_t got);
            result_t want;
            if (pending.size() == 0)
            begin
                fails++;
                if (shown < SHOW_LIMIT)
                    $display("unexpected result %h %h %h with nothing pending",
                             got.drive_red, got.drive_green, got.drive_blue);
                shown++;
                return;
            end
            want = pending.pop_front();
            checked++;
            if (got.drive_red !== want.drive_red || got.drive_green !== want.drive_green
                || got.drive_blue !== want.drive_blue)
            begin
                fails++;
                if (shown < SHOW_LIMIT)
                    $display("result %0d mismatch: expected r=%h g=%h b=%h, got r=%h g=%h b=%h",
                             checked, want.drive_red, want.drive_green, want.drive_blue,
                             got.drive_red, got.drive_green, got.drive_blue);
                shown++;
            end
        endfunction
    endclass

    // ------------------------------------------------------------------------
    // Clock, reset and the block's ports.
    // ------------------------------------------------------------------------
    logic                   clk = 1'b0;
    logic                   rst_n = 1'b0;
    logic                   item_valid = 1'b0;
    logic                   item_stall;
    item_t                  item = '0;
    logic                   result_valid;
    logic                   result_stall = 1'b0;
    result_t                result;
    logic                   cfg_we = 1'b0;
    logic [CFG_INDEX_W-1:0] cfg_index = '0;
    logic [CFG_DATA_W-1:0]  cfg_data = '0;

    pixel_scoreboard board;

    // Receiver control. The main process asks for a long hold-off by bumping
    // hold_req; the receiver counts the hold itself. While quiet is set,
    // neither side idles.
    int hold_req = 0;
    int hold_served = 0;
    int hold_left = 0;
    int stall_left = 0;
    int stall_pick;
    logic quiet = 1'b0;

    int cycle_count = 0;
    int settings = 1;
    int colour_items = 0;

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    rgb_fade_breathe_driver_core u_dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .item_valid   (item_valid),
        .item_stall   (item_stall),
        .item         (item),
        .result_valid (result_valid),
        .result_stall (result_stall),
        .result       (result),
        .cfg_we       (cfg_we),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data)
    );

    // A run that hangs, for instance with a result that never comes, ends here.
    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("timeout after %0d cycles, %0d results outstanding",
                     cycle_count, board.pending.size());
            $display("TB_ERROR");
            $finish;
        end
    end

    // Result side: check every accepted result, then decide the stall for the
    // next cycle. Values read here are the ones the block saw at this edge.
    always @(posedge clk)
    begin
        if (rst_n && result_valid && !result_stall)
            board.check_result(result);
        if (hold_served != hold_req)
        begin
            hold_served = hold_req;
            hold_left   = HOLD_CYCLES;
        end
        if (hold_left > 0)
        begin
            hold_left--;
            result_stall <= 1'b1;
        end
        else if (quiet)
            result_stall <= 1'b0;
        else if (stall_left > 0)
        begin
            stall_left--;
            result_stall <= 1'b1;
        end
        else
        begin
            // Mostly no stall, often a short one, now and then a long one.
            stall_pick = $urandom_range(0, 99);
            if (stall_pick < 60)
                result_stall <= 1'b0;
            else if (stall_pick < 92)
            begin
                stall_left   = $urandom_range(0, 2);
                result_stall <= 1'b1;
            end
            else
            begin
                stall_left   = $urandom_range(8, 40);
                result_stall <= 1'b1;
            end
        end
    end

    // ------------------------------------------------------------------------
    // Stimulus tasks.
    // ------------------------------------------------------------------------
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (quiet || r < 55)
            return 0;
        if (r < 90)
            return $urandom_range(1, 3);
        return $urandom_range(5, 30);
    endfunction

    function automatic item_t make_item(input logic [1:0] code, input logic [7:0] red,
                                        input logic [7:0] green, input logic [7:0] blue,
                                        input logic pulse);
        item_t it;
        it.cmd          = code;
        it.target_red   = red;
        it.target_green = green;
        it.target_blue  = blue;
        it.pulse_enable = pulse;
        return it;
    endfunction

    // Random colour content; on tick and off items the fields are don't-care.
    function automatic item_t random_item(input logic [1:0] code);
        return make_item(code, 8'($urandom), 8'($urandom), 8'($urandom), 1'($urandom));
    endfunction

    // Offer one item after a gap and return at the edge where it is taken.
    // Valid is left high so that a back-to-back item never lowers and raises
    // it within one time step.
    task automatic send_item(input item_t it, input int gap);
        if (gap > 0)
        begin
            item_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        item_valid <= 1'b1;
        item       <= it;
        do
            @(posedge clk);
        while (item_stall);
        board.note_item(it);
        if (it.cmd != CMD_UNUSED)
            colour_items++;
    endtask

    // Stop sending, wait for every expected result, then let a set item or an
    // ignored code still inside the block run out.
    task automatic wait_for_results();
        item_valid <= 1'b0;
        while (board.pending.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    // Write both rate registers on back-to-back edges; the block is idle.
    task automatic program_rates(input logic [FADE_W-1:0] fade_val,
                                 input logic [PSTEP_W-1:0] phase_val);
        cfg_we    <= 1'b1;
        cfg_index <= CFG_FADE_STEP;
        cfg_data  <= CFG_DATA_W'(fade_val);
        @(posedge clk);
        board.fade_rate = fade_val;
        cfg_index <= CFG_PHASE_STEP;
        cfg_data  <= CFG_DATA_W'(phase_val);
        @(posedge clk);
        board.phase_rate = phase_val;
        cfg_we <= 1'b0;
        settings++;
    endtask

    function automatic logic [FADE_W-1:0] pick_fade();
        case ($urandom_range(0, 7))
            0: return '0;
            1: return FADE_W'(1);
            2: return FADE_FULL;
            3: return FADE_W'(511);
            4: return FADE_W'($urandom_range(257, 510));
            5: return FADE_W'($urandom_range(64, 255));
            default: return FADE_W'($urandom_range(2, 63));
        endcase
    endfunction

    function automatic logic [PSTEP_W-1:0] pick_phase_step();
        case ($urandom_range(0, 5))
            0: return '0;
            1: return PSTEP_W'(1);
            2: return PSTEP_W'(1023);
            3: return PSTEP_W'(512);
            default: return PSTEP_W'($urandom);
        endcase
    endfunction

    // ------------------------------------------------------------------------
    // Main sequence.
    // ------------------------------------------------------------------------
    initial
    begin
        int phase_no;
        int in_phase;
        int run;
        int pick;

        board = new();
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed opening at the reset rates: a tick from black, a fade up
        // toward full white, then a breathing colour with channel extremes.
        send_item(make_item(CMD_TICK, 8'hFF, 8'hFF, 8'hFF, 1'b1), 0);
        send_item(make_item(CMD_SET, 8'hFF, 8'hFF, 8'hFF, 1'b0), 0);
        repeat (3) send_item(random_item(CMD_TICK), 0);
        send_item(make_item(CMD_SET, 8'h00, 8'h80, 8'hFF, 1'b1), 1);
        repeat (2) send_item(random_item(CMD_TICK), 0);
        // The unused code must change nothing and give no result.
        send_item(make_item(CMD_UNUSED, 8'hFF, 8'hFF, 8'hFF, 1'b1), 0);
        send_item(random_item(CMD_TICK), 0);
        // Off gives an all-zero result and clears breathing.
        send_item(make_item(CMD_OFF, 8'hFF, 8'hFF, 8'hFF, 1'b1), 0);
        send_item(random_item(CMD_TICK), 2);
        wait_for_results();

        // Full step with the widest phase step: the goal is reached in one
        // tick, and the phase wraps.
        program_rates(FADE_FULL, PSTEP_W'(1023));
        send_item(make_item(CMD_SET, 8'hFF, 8'h00, 8'hAA, 1'b1), 0);
        repeat (3) send_item(random_item(CMD_TICK), 0);
        send_item(make_item(CMD_SET, 8'h00, 8'hFF, 8'h55, 1'b0), 0);
        send_item(random_item(CMD_TICK), 0);
        wait_for_results();

        // A fade step of zero holds the channels, a phase step of zero
        // freezes the breathing.
        program_rates('0, '0);
        send_item(make_item(CMD_SET, 8'h01, 8'hFE, 8'h00, 1'b1), 0);
        repeat (2) send_item(random_item(CMD_TICK), 0);
        wait_for_results();

        // A fade step above 256 saturates to a full step.
        program_rates(FADE_W'(511), PSTEP_W'(1));
        send_item(random_item(CMD_TICK), 0);
        wait_for_results();

        // The smallest nonzero fade step moves by ceil(distance / 256), at least one LSB per tick.
        program_rates(FADE_W'(1), PSTEP_W'(512));
        send_item(make_item(CMD_SET, 8'hFF, 8'h7F, 8'h01, 1'b1), 0);
        repeat (3) send_item(random_item(CMD_TICK), 0);
        wait_for_results();

        // Random phases, each at fresh rates. Most traffic is a set followed
        // by a run of ticks so that fades and breathing develop; lone ticks,
        // off items and the unused code are mixed in.
        colour_items = 0;
        phase_no = 0;
        while (colour_items < RANDOM_ITEMS)
        begin
            wait_for_results();
            program_rates(pick_fade(), pick_phase_step());
            quiet <= (phase_no % 4 == 2);
            if (phase_no == 1)
            begin
                // Long hold-off on the result side while ticks keep coming
                // back to back; the block fills and stalls its input.
                hold_req <= hold_req + 1;
                send_item(make_item(CMD_SET, 8'($urandom), 8'($urandom), 8'($urandom), 1'b1), 0);
                repeat (30) send_item(random_item(CMD_TICK), 0);
                // Pause until everything the burst caused has come out.
                wait_for_results();
            end
            in_phase = 0;
            while (in_phase < 100 && colour_items < RANDOM_ITEMS)
            begin
                pick = $urandom_range(0, 99);
                if (pick < 4)
                    send_item(random_item(CMD_UNUSED), pick_gap());
                else if (pick < 10)
                begin
                    send_item(random_item(CMD_OFF), pick_gap());
                    in_phase++;
                end
                else if (pick < 15)
                begin
                    send_item(random_item(CMD_TICK), pick_gap());
                    in_phase++;
                end
                else
                begin
                    send_item(random_item(CMD_SET), pick_gap());
                    run = $urandom_range(1, 25);
                    repeat (run) send_item(random_item(CMD_TICK), pick_gap());
                    in_phase += run + 1;
                end
            end
            phase_no++;
        end

        wait_for_results();

        $display("Checked %0d results from %0d ticks and %0d off items; %0d sets, %0d ignored codes.",
                 board.checked, board.ticks, board.offs, board.sets, board.ignored);
        $display("Ran %0d rate settings, including zero, one, full and saturated fade steps.",
                 settings);
        if (board.fails == 0 && board.pending.size() == 0)
            $display("TB_OK");
        else
        begin
            $display("%0d failures, %0d results outstanding", board.fails, board.pending.size());
            $display("TB_ERROR");
        end
        $finish;
    end

endmodule
